### src/radial_distance_rescale_defines.svh
// Assertion macros shared by the radial distance rescale RTL.
// Depends on nothing; the including module provides clock and reset.
`ifndef RADIAL_DISTANCE_RESCALE_DEFINES_SVH
`define RADIAL_DISTANCE_RESCALE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RDR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RDR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rdr_pkg.sv
// Shared widths, register indexes, mode codes and sideband types
// for the radial distance rescale pipeline. No dependencies.
package rdr_pkg;

   localparam int CoordW    = 32;
   localparam int MagW      = 32;
   localparam int Lanes     = 4;
   localparam int SumW      = 66;
   localparam int RootPairs = 33;
   localparam int RootW     = 33;
   localparam int Sqrt2Pairs = 25;
   localparam int NsqrtW    = 25;
   localparam int RadiusW   = 31;
   localparam int ProdW     = 64;
   localparam int UW        = 65;
   localparam int MsbW      = 7;
   localparam int ExpW      = 6;
   localparam int FracBits  = 16;
   localparam int NlogW     = ExpW + FracBits;
   localparam int NumW      = 94;
   localparam int DenW      = 66;
   localparam int FactW     = 64;
   localparam int CapW      = 41;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 32;
   localparam int ModeW     = 2;

   localparam logic [CsrIdxW-1:0] CSR_CENTER_X     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_CENTER_Y     = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_CENTER_Z     = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_FIXED_RADIUS = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_LOG_SCALE    = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_MAPPING_MODE = 3'd5;

   localparam logic [ModeW-1:0] MODE_IDENTITY = 2'd0;
   localparam logic [ModeW-1:0] MODE_INVERT   = 2'd1;
   localparam logic [ModeW-1:0] MODE_SQRT     = 2'd2;
   localparam logic [ModeW-1:0] MODE_LOG      = 2'd3;

   typedef struct packed {
      logic            neg;
      logic [MagW-1:0] mag;
   } lane_type;

   typedef lane_type [Lanes-1:0] offs_type;

   typedef struct packed {
      offs_type        offs;
      logic [SumW-1:0] s;
   } sq_side_type;

   typedef struct packed {
      offs_type         offs;
      logic [SumW-1:0]  s;
      logic [RootW-1:0] r;
   } root_side_type;

   typedef struct packed {
      offs_type          offs;
      logic [SumW-1:0]   s;
      logic [RootW-1:0]  r;
      logic [NsqrtW-1:0] n_sqrt;
   } log_side_type;

   typedef struct packed {
      offs_type offs;
      logic     unity;
   } div_side_type;

endpackage

### src/rdr_isqrt_pipe.sv
// Pipelined floor square root, one result bit per stage.
// Depends on nothing; sideband bits travel alongside unchanged.
module rdr_isqrt_pipe #(
   parameter int PAIRS  = 33,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2*PAIRS-1:0]   in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [PAIRS-1:0]     out_root,
   output logic [SIDE_W-1:0]    out_side
);
   localparam int RadW = 2 * PAIRS;
   localparam int RemW = PAIRS + 2;

   logic [PAIRS-1:0]  valid_ff;
   logic [RemW-1:0]   rem_ff  [PAIRS];
   logic [PAIRS-1:0]  root_ff [PAIRS];
   logic [RadW-1:0]   rad_ff  [PAIRS];
   logic [SIDE_W-1:0] side_ff [PAIRS];

   for (genvar i = 0; i < PAIRS; i++) begin : g_stage
      logic              vld_prev;
      logic [RemW-1:0]   rem_prev;
      logic [PAIRS-1:0]  root_prev;
      logic [RadW-1:0]   rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RemW+1:0]   rem_t;
      logic [RemW+1:0]   trial;
      logic [RemW+1:0]   diff;
      logic              ge;
      logic [RemW-1:0]   rem_in;
      logic [PAIRS-1:0]  root_in;
      logic [RadW-1:0]   rad_in;

      if (i == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = valid_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         rem_t   = {rem_prev, rad_prev[RadW-1 -: 2]};
         trial   = {2'b00, root_prev, 2'b01};
         ge      = (rem_t >= trial);
         diff    = rem_t - trial;
         rem_in  = ge ? diff[RemW-1:0] : rem_t[RemW-1:0];
         root_in = {root_prev[PAIRS-2:0], ge};
         rad_in  = {rad_prev[RadW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            rad_ff[i]  <= rad_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[PAIRS-1];
   assign out_root  = root_ff[PAIRS-1];
   assign out_side  = side_ff[PAIRS-1];
endmodule

### src/rdr_log_pipe.sv
// Pipelined log2(1 + r*scale) in unsigned Q6.16 by mantissa squaring.
// Depends on rdr_pkg for the field widths.
module rdr_log_pipe #(
   parameter int SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [rdr_pkg::RootW-1:0]    in_r,
   input  logic [rdr_pkg::RadiusW-1:0]  in_scale,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [rdr_pkg::NlogW-1:0]    out_n,
   output logic [SIDE_W-1:0]            out_side
);
   localparam int Steps = rdr_pkg::FracBits;

   // front: product, offset add, leading-one search, normalize
   logic                        v0_ff, v1_ff, v2_ff, v3_ff;
   logic [SIDE_W-1:0]           side0_ff, side1_ff, side2_ff, side3_ff;
   logic [rdr_pkg::ProdW-1:0]   prod_ff, prod_in;
   logic [rdr_pkg::UW-1:0]      u_ff, u_in, u2_ff;
   logic [rdr_pkg::MsbW-1:0]    msb_ff, msb_in;
   logic [31:0]                 y0_ff, y0_in;
   logic [rdr_pkg::ExpW-1:0]    expo0_ff, expo0_in;

   logic [Steps-1:0]            valid_ff;
   logic [31:0]                 y_ff    [Steps];
   logic [Steps-1:0]            frac_ff [Steps];
   logic [rdr_pkg::ExpW-1:0]    expo_ff [Steps];
   logic [SIDE_W-1:0]           side_ff [Steps];

   assign prod_in = {31'b0, in_r} * {33'b0, in_scale};
   assign u_in    = {1'b0, prod_ff} + (65'd1 << 32);

   always_comb begin
      msb_in = '0;
      for (int i = 0; i < rdr_pkg::UW; i++) begin
         if (u_ff[i]) begin
            msb_in = rdr_pkg::MsbW'(i);
         end
      end
   end

   assign y0_in    = 32'(u2_ff >> (msb_ff - 7'd31));
   assign expo0_in = rdr_pkg::ExpW'(msb_ff - 7'd32);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         side0_ff <= in_side;
         u_ff     <= u_in;
         side1_ff <= side0_ff;
         msb_ff   <= msb_in;
         u2_ff    <= u_ff;
         side2_ff <= side1_ff;
         y0_ff    <= y0_in;
         expo0_ff <= expo0_in;
         side3_ff <= side2_ff;
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_sq
      logic                     vld_prev;
      logic [31:0]              y_prev;
      logic [Steps-1:0]         frac_prev;
      logic [rdr_pkg::ExpW-1:0] expo_prev;
      logic [SIDE_W-1:0]        side_prev;
      logic [63:0]              sq;
      logic [32:0]              t;
      logic [31:0]              y_in;
      logic [Steps-1:0]         frac_in;

      if (i == 0) begin : g_first
         assign vld_prev  = v3_ff;
         assign y_prev    = y0_ff;
         assign frac_prev = '0;
         assign expo_prev = expo0_ff;
         assign side_prev = side3_ff;
      end else begin : g_next
         assign vld_prev  = valid_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign frac_prev = frac_ff[i-1];
         assign expo_prev = expo_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // square the mantissa; a carry past bit 32 yields a fraction bit
      always_comb begin
         sq      = {32'b0, y_prev} * {32'b0, y_prev};
         t       = sq[63:31];
         y_in    = t[32] ? t[32:1] : t[31:0];
         frac_in = {frac_prev[Steps-2:0], t[32]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            y_ff[i]    <= y_in;
            frac_ff[i] <= frac_in;
            expo_ff[i] <= expo_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_n     = {expo_ff[Steps-1], frac_ff[Steps-1]};
   assign out_side  = side_ff[Steps-1];
endmodule

### src/rdr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit. No dependencies.
module rdr_div_pipe #(
   parameter int NUM_W  = 94,
   parameter int DEN_W  = 66,
   parameter int Q_W    = 64,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_q,
   output logic              out_ovf,
   output logic [SIDE_W-1:0] out_side
);
   localparam int Depth = Q_W + 1;
   localparam int HiW   = NUM_W - Q_W;

   logic [Depth-1:0]  valid_ff;
   logic [DEN_W-1:0]  rem_ff  [Depth];
   logic [Q_W-1:0]    low_ff  [Depth];
   logic [DEN_W-1:0]  den_ff  [Depth];
   logic              ovf_ff  [Depth];
   logic [SIDE_W-1:0] side_ff [Depth];

   logic [DEN_W-1:0] top_ext;
   assign top_ext = {{(DEN_W-HiW){1'b0}}, in_num[NUM_W-1:Q_W]};

   // entry stage: upper numerator bits seed the remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= top_ext;
         low_ff[0]  <= in_num[Q_W-1:0];
         den_ff[0]  <= in_den;
         ovf_ff[0]  <= (top_ext >= in_den);
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 1; i < Depth; i++) begin : g_stage
      logic [DEN_W:0]   rem_t;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [Q_W-1:0]   low_in;

      // quotient bits shift into the vacated low numerator bits
      always_comb begin
         rem_t  = {rem_ff[i-1], low_ff[i-1][Q_W-1]};
         ge     = (rem_t >= {1'b0, den_ff[i-1]});
         diff   = rem_t - {1'b0, den_ff[i-1]};
         rem_in = ge ? diff[DEN_W-1:0] : rem_t[DEN_W-1:0];
         low_in = {low_ff[i-1][Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            low_ff[i]  <= low_in;
            den_ff[i]  <= den_ff[i-1];
            ovf_ff[i]  <= ovf_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[Depth-1];
   assign out_q     = low_ff[Depth-1];
   assign out_ovf   = ovf_ff[Depth-1];
   assign out_side  = side_ff[Depth-1];
endmodule

### src/rdr_scale_pipe.sv
// Three-stage output scaler: offset times factor, rounding, center add
// and saturation for all lanes. Depends on rdr_pkg.
module rdr_scale_pipe (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        en,
   input  logic                                        in_valid,
   input  logic [rdr_pkg::FactW-1:0]                   in_f,
   input  rdr_pkg::offs_type                           in_offs,
   input  logic [rdr_pkg::Lanes-1:0][rdr_pkg::CoordW-1:0] in_base,
   output logic                                        out_valid,
   output logic [rdr_pkg::Lanes-1:0][rdr_pkg::CoordW-1:0] out_res
);
   localparam int L = rdr_pkg::Lanes;

   logic        v1_ff, v2_ff, v3_ff;
   logic [63:0] pl_ff [L];
   logic [63:0] ph_ff [L];
   logic [L-1:0] neg1_ff, neg2_ff;
   logic [31:0] base1_ff [L];
   logic [31:0] base2_ff [L];
   logic [rdr_pkg::CapW-1:0] m_ff [L];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   for (genvar i = 0; i < L; i++) begin : g_lane
      logic [63:0]              pl_in, ph_in;
      logic [64:0]              plr;
      logic [64:0]              m_full;
      logic [rdr_pkg::CapW-1:0] m_in;
      logic signed [42:0]       base_ext, m_ext, sum;
      logic [31:0]              res_in;

      // split the 64-bit factor into two 32x32 partial products
      assign pl_in = {32'b0, in_offs[i].mag} * {32'b0, in_f[31:0]};
      assign ph_in = {32'b0, in_offs[i].mag} * {32'b0, in_f[63:32]};

      // round half away from zero on the magnitude, then cap
      always_comb begin
         plr    = {1'b0, pl_ff[i]} + 65'h0_8000_0000;
         m_full = {1'b0, ph_ff[i]} + {32'b0, plr[64:32]};
         m_in   = (m_full > 65'h100_0000_0000) ? 41'h100_0000_0000 : m_full[40:0];
      end

      always_comb begin
         base_ext = {{11{base2_ff[i][31]}}, base2_ff[i]};
         m_ext    = {2'b00, m_ff[i]};
         sum      = neg2_ff[i] ? (base_ext - m_ext) : (base_ext + m_ext);
         if (sum > 43'sd2147483647) begin
            res_in = 32'h7FFF_FFFF;
         end else if (sum < -43'sd2147483648) begin
            res_in = 32'h8000_0000;
         end else begin
            res_in = sum[31:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pl_ff[i]    <= pl_in;
            ph_ff[i]    <= ph_in;
            neg1_ff[i]  <= in_offs[i].neg;
            base1_ff[i] <= in_base[i];
            m_ff[i]     <= m_in;
            neg2_ff[i]  <= neg1_ff[i];
            base2_ff[i] <= base1_ff[i];
            out_res[i]  <= res_in;
         end
      end
   end

   assign out_valid = v3_ff;
endmodule

### src/radial_distance_rescale.sv
// Radial distance rescale: takes one point (x, y, z, signed Q16.16) with an
// attached sample value per transaction and returns the point moved along
// its ray from the configured center, plus the value scaled by the same
// factor new_radius / r, all saturated to Q16.16. The mapping_mode register
// selects identity, inversion about fixed_radius, square root, or
// log2(1 + r*log_scale); a point on the center passes through unchanged.
// The block is a fully pipelined datapath that takes one transaction every
// clock while the output is not held, through stages for offsets, squares
// and their sum, the radius square root (one bit per stage), the square-root
// mapping, the log unit, operand selection, the factor divider (one quotient
// bit per stage) and scaling and saturation. When the output is held, every
// stage holds with it. Write configuration only while no transaction is in
// flight. Depends on rdr_pkg, the rdr_* submodules and
// radial_distance_rescale_defines.svh.
`include "radial_distance_rescale_defines.svh"

module radial_distance_rescale (
   input  logic                            clock,
   input  logic                            reset,
   // fields from bit 0 up: point_x, point_y, point_z, sample_value
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [127:0]                    req_tdata,
   // fields from bit 0 up: scaled_x, scaled_y, scaled_z, scaled_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [127:0]                    rsp_tdata,
   input  logic                            csr_we,
   input  logic [rdr_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [rdr_pkg::CsrDataW-1:0]    csr_wdata
);
   localparam int L = rdr_pkg::Lanes;

   // configuration registers
   logic [31:0]                   center_x_ff, center_y_ff, center_z_ff;
   logic [rdr_pkg::RadiusW-1:0]   fixed_radius_ff, log_scale_ff;
   logic [rdr_pkg::ModeW-1:0]     mapping_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         center_z_ff     <= '0;
         fixed_radius_ff <= 31'd65536;
         log_scale_ff    <= 31'd65536;
         mapping_mode_ff <= rdr_pkg::MODE_INVERT;
      end else if (csr_we) begin
         unique case (csr_index)
            rdr_pkg::CSR_CENTER_X:     center_x_ff     <= csr_wdata;
            rdr_pkg::CSR_CENTER_Y:     center_y_ff     <= csr_wdata;
            rdr_pkg::CSR_CENTER_Z:     center_z_ff     <= csr_wdata;
            rdr_pkg::CSR_FIXED_RADIUS: fixed_radius_ff <= csr_wdata[30:0];
            rdr_pkg::CSR_LOG_SCALE:    log_scale_ff    <= csr_wdata[30:0];
            rdr_pkg::CSR_MAPPING_MODE: mapping_mode_ff <= csr_wdata[1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // one enable for every stage: advance unless the result is held
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // lane 3 carries the sample value against a zero base
   logic [L-1:0][31:0] base_vec;
   assign base_vec = {32'b0, center_z_ff, center_y_ff, center_x_ff};

   // stage A: signed offsets from the center as sign and magnitude
   rdr_pkg::offs_type offs_a_in, offs_a_ff;
   logic              a_valid_ff;

   for (genvar i = 0; i < L; i++) begin : g_off
      logic [32:0] diff;
      logic [32:0] neg_diff;
      assign diff     = {req_tdata[32*i+31], req_tdata[32*i +: 32]}
                      - {base_vec[i][31], base_vec[i]};
      assign neg_diff = -diff;
      assign offs_a_in[i].neg = diff[32];
      assign offs_a_in[i].mag = diff[32] ? neg_diff[31:0] : diff[31:0];
   end

   // stage B: squares; stage C: sum of squares (exact Q34.32)
   logic [63:0]              sq_ff [3];
   rdr_pkg::offs_type        offs_b_ff, offs_c_ff;
   logic                     b_valid_ff, c_valid_ff;
   logic [rdr_pkg::SumW-1:0] s_ff, s_in;

   assign s_in = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         offs_a_ff <= offs_a_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= {32'b0, offs_a_ff[i].mag} * {32'b0, offs_a_ff[i].mag};
         end
         offs_b_ff <= offs_a_ff;
         s_ff      <= s_in;
         offs_c_ff <= offs_b_ff;
      end
   end

   // radius r = floor(sqrt(S))
   rdr_pkg::sq_side_type     sq_side_c, sq_side_r;
   logic                     r_valid;
   logic [rdr_pkg::RootW-1:0] r_root;

   assign sq_side_c = '{offs: offs_c_ff, s: s_ff};

   rdr_isqrt_pipe #(
      .PAIRS  (rdr_pkg::RootPairs),
      .SIDE_W ($bits(rdr_pkg::sq_side_type))
   ) u_radius (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .in_rad    (s_ff),
      .in_side   (sq_side_c),
      .out_valid (r_valid),
      .out_root  (r_root),
      .out_side  (sq_side_r)
   );

   // square-root mapping: n = floor(sqrt(r * 2^16))
   rdr_pkg::root_side_type     root_side_r, root_side_n;
   logic                       n_valid;
   logic [rdr_pkg::NsqrtW-1:0] n_sqrt;

   assign root_side_r = '{offs: sq_side_r.offs, s: sq_side_r.s, r: r_root};

   rdr_isqrt_pipe #(
      .PAIRS  (rdr_pkg::Sqrt2Pairs),
      .SIDE_W ($bits(rdr_pkg::root_side_type))
   ) u_sqrt_map (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid),
      .in_rad    ({1'b0, r_root, 16'b0}),
      .in_side   (root_side_r),
      .out_valid (n_valid),
      .out_root  (n_sqrt),
      .out_side  (root_side_n)
   );

   // log mapping, computed for every transaction and picked by mode later
   rdr_pkg::log_side_type     log_side_in, log_side_out;
   logic                      l_valid;
   logic [rdr_pkg::NlogW-1:0] n_log;

   assign log_side_in = '{offs: root_side_n.offs, s: root_side_n.s,
                          r: root_side_n.r, n_sqrt: n_sqrt};

   rdr_log_pipe #(
      .SIDE_W ($bits(rdr_pkg::log_side_type))
   ) u_log_map (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (n_valid),
      .in_r      (root_side_n.r),
      .in_scale  (log_scale_ff),
      .in_side   (log_side_in),
      .out_valid (l_valid),
      .out_n     (n_log),
      .out_side  (log_side_out)
   );

   // stage D: choose dividend and divisor by mapping mode
   logic [61:0]               rr;
   logic [rdr_pkg::NumW-1:0]  num_in, num_ff;
   logic [rdr_pkg::DenW-1:0]  den_in, den_ff;
   logic                      unity_in;
   rdr_pkg::div_side_type     dside_ff, dside_out;
   logic                      d_valid_ff;

   assign rr = {31'b0, fixed_radius_ff} * {31'b0, fixed_radius_ff};

   always_comb begin
      unity_in = (log_side_out.r == '0);
      num_in   = '0;
      den_in   = {{(rdr_pkg::DenW-1){1'b0}}, 1'b1};
      unique case (mapping_mode_ff)
         rdr_pkg::MODE_IDENTITY: begin
            unity_in = 1'b1;
         end
         rdr_pkg::MODE_INVERT: begin
            num_in = {rr, 32'b0};
            den_in = log_side_out.s;
         end
         rdr_pkg::MODE_SQRT: begin
            num_in = {37'b0, log_side_out.n_sqrt, 32'b0};
            den_in = {33'b0, log_side_out.r};
         end
         rdr_pkg::MODE_LOG: begin
            num_in = {40'b0, n_log, 32'b0};
            den_in = {33'b0, log_side_out.r};
         end
      endcase
      // a unit factor needs no quotient; keep the divider out of overflow
      if (unity_in) begin
         num_in = '0;
         den_in = {{(rdr_pkg::DenW-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= l_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         dside_ff <= '{offs: log_side_out.offs, unity: unity_in};
      end
   end

   // factor F in Q.32
   logic                      div_valid;
   logic [rdr_pkg::FactW-1:0] div_q;
   logic                      div_ovf;

   rdr_div_pipe #(
      .NUM_W  (rdr_pkg::NumW),
      .DEN_W  (rdr_pkg::DenW),
      .Q_W    (rdr_pkg::FactW),
      .SIDE_W ($bits(rdr_pkg::div_side_type))
   ) u_factor (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (dside_ff),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_ovf   (div_ovf),
      .out_side  (dside_out)
   );

   // unit factor wins, then saturate an oversized quotient
   logic [rdr_pkg::FactW-1:0] factor;

   always_comb begin
      priority if (dside_out.unity) begin
         factor = 64'h0000_0001_0000_0000;
      end else if (div_ovf) begin
         factor = '1;
      end else begin
         factor = div_q;
      end
   end

   logic [L-1:0][31:0] scaled;

   rdr_scale_pipe u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_f      (factor),
      .in_offs   (dside_out.offs),
      .in_base   (base_vec),
      .out_valid (rsp_tvalid),
      .out_res   (scaled)
   );

   assign rsp_tdata = scaled;

   // only the inversion can produce a quotient of 2^64 or more
   `RDR_ASSERT_IMPLY(a_ovf_invert_only, div_valid && div_ovf && !dside_out.unity, mapping_mode_ff == rdr_pkg::MODE_INVERT, "factor overflow outside invert mode")
   // a held result must freeze the front of the pipeline
   `RDR_ASSERT_NEXT(a_stall_freezes, !en, $stable(c_valid_ff) && $stable(s_ff), "pipeline advanced while output held")
   // a unit factor always reaches the divider with a divisor of one
   `RDR_ASSERT_IMPLY(a_unity_den, d_valid_ff && dside_ff.unity, den_ff == {{(rdr_pkg::DenW-1){1'b0}}, 1'b1}, "unit factor with live divisor")
endmodule
